/* hdl/fxalu_pkg.sv */
// Package: Q24.8 ALU constants, operation codes, item and cell types.
`default_nettype none
package fxalu_pkg;

  localparam int FRAC_BITS = 8;
  localparam int MANT_BITS = 23;
  localparam int EXP_BIAS  = 127;
  localparam int SIGN_POS  = 31;
  localparam int DIV_W     = 32 + FRAC_BITS;
  localparam int CNT_W     = $clog2(DIV_W + 1);
  localparam int EXP_TOP   = EXP_BIAS + SIGN_POS - FRAC_BITS;

  typedef enum logic [3:0] {
    OP_FROM_INT   = 4'd0,
    OP_FROM_FLOAT = 4'd1,
    OP_TO_FLOAT   = 4'd2,
    OP_TO_INT     = 4'd3,
    OP_ADD        = 4'd4,
    OP_SUB        = 4'd5,
    OP_MUL        = 4'd6,
    OP_DIV        = 4'd7,
    OP_CMP        = 4'd8,
    OP_MIN        = 4'd9,
    OP_MAX        = 4'd10,
    OP_INC        = 4'd11,
    OP_DEC        = 4'd12
  } op_e;

  typedef struct packed {
    logic [3:0]         operation;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic [31:0]        float_bits;
  } in_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        less;
    logic        equal;
    logic        greater;
    logic        overflow;
    logic        divide_by_zero;
  } out_t;

  // wide: mul product, or float fields {spec_ovf, special, big, rbit, base[32:0]}
  typedef struct packed {
    op_e              op;
    logic [31:0]      a;
    logic [31:0]      res;
    logic             lt;
    logic             eq;
    logic             gt;
    logic [63:0]      wide;
    logic [31:0]      rem;
    logic [DIV_W-1:0] qd;
    logic [31:0]      dmag;
    logic             qsign;
    logic [CNT_W-1:0] cnt;
  } cell_t;

endpackage
`default_nettype wire

/* hdl/fxalu_pre.sv */
// Front stage: decode item, simple results, multiply, divide and convert setup.
`default_nettype none
module fxalu_pre (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               en_i,
  input  wire               vld_i,
  input  fxalu_pkg::in_t    in_i,
  output logic              vld_o,
  output fxalu_pkg::cell_t  dat_o
);
  import fxalu_pkg::*;

  logic               vld_q;
  cell_t              dat_d, dat_q;
  logic signed [63:0] prod;
  logic signed [DIV_W-1:0] dvd;
  logic [31:0]        amag;
  logic [7:0]         bexp;
  logic [23:0]        mant;
  logic signed [9:0]  sh;
  logic [9:0]         shl;
  logic [32:0]        rtmp;

  always_comb begin
    prod   = in_i.operand_a * in_i.operand_b;
    dvd    = DIV_W'(in_i.operand_a) <<< FRAC_BITS;
    amag   = in_i.operand_a[31] ? 32'(-in_i.operand_a) : 32'(in_i.operand_a);
    bexp   = in_i.float_bits[30:23];
    mant   = {1'b1, in_i.float_bits[22:0]};
    sh     = 10'(MANT_BITS - FRAC_BITS + EXP_BIAS) - $signed({2'b00, bexp});
    shl    = 10'(-sh);
    rtmp   = {9'b0, mant} >> (sh[4:0] - 5'd1);
    dat_d  = '0;
    dat_d.op = op_e'(in_i.operation);
    dat_d.a  = in_i.operand_a;
    unique case (op_e'(in_i.operation))
      OP_FROM_INT: dat_d.res = in_i.operand_a << FRAC_BITS;
      OP_TO_INT:   dat_d.res = in_i.operand_a >>> FRAC_BITS;
      OP_ADD:      dat_d.res = in_i.operand_a + in_i.operand_b;
      OP_SUB:      dat_d.res = in_i.operand_a - in_i.operand_b;
      OP_INC:      dat_d.res = in_i.operand_a + 32'sd1;
      OP_DEC:      dat_d.res = in_i.operand_a - 32'sd1;
      OP_MIN: dat_d.res = (in_i.operand_a > in_i.operand_b) ? in_i.operand_b : in_i.operand_a;
      OP_MAX: dat_d.res = (in_i.operand_b > in_i.operand_a) ? in_i.operand_b : in_i.operand_a;
      OP_CMP: begin
        dat_d.lt = in_i.operand_a < in_i.operand_b;
        dat_d.eq = in_i.operand_a == in_i.operand_b;
        dat_d.gt = in_i.operand_a > in_i.operand_b;
      end
      OP_MUL: dat_d.wide = prod;
      OP_DIV: begin
        dat_d.qd    = dvd[DIV_W-1] ? DIV_W'(-dvd) : DIV_W'(dvd);
        dat_d.dmag  = in_i.operand_b[31] ? 32'(-in_i.operand_b) : 32'(in_i.operand_b);
        dat_d.qsign = in_i.operand_a[31] ^ in_i.operand_b[31];
      end
      OP_TO_FLOAT: dat_d.qd[DIV_W-1 -: 32] = amag;
      OP_FROM_FLOAT: begin
        dat_d.qsign = in_i.float_bits[31];
        if (bexp == 8'd0) begin
          dat_d.wide[35] = 1'b1;
        end else if (bexp == 8'hFF) begin
          dat_d.wide[35] = 1'b1;
          dat_d.wide[36] = 1'b1;
          dat_d.res = ((in_i.float_bits[22:0] != 23'd0) || !in_i.float_bits[31]) ?
                      32'h7FFF_FFFF : 32'h8000_0000;
        end else if (sh > 10'sd0) begin
          if (sh < 10'sd32) begin
            dat_d.wide[32:0] = {9'b0, mant} >> sh[4:0];
            dat_d.wide[33]   = rtmp[0];
          end
        end else if (shl >= 10'd9) begin
          dat_d.wide[34] = 1'b1;
        end else begin
          dat_d.wide[32:0] = {9'b0, mant} << shl[3:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;

endmodule
`default_nettype wire

/* hdl/fxalu_cell.sv */
// Chain cell: one restoring divide step or one normalize step per item.
`default_nettype none
module fxalu_cell (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               en_i,
  input  wire               vld_i,
  input  fxalu_pkg::cell_t  dat_i,
  output logic              vld_o,
  output fxalu_pkg::cell_t  dat_o
);
  import fxalu_pkg::*;

  logic        vld_q;
  cell_t       dat_d, dat_q;
  logic [32:0] r2;
  logic [32:0] diff;
  logic        qbit;

  always_comb begin
    dat_d = dat_i;
    r2    = {dat_i.rem, dat_i.qd[DIV_W-1]};
    diff  = r2 - {1'b0, dat_i.dmag};
    qbit  = (r2 >= {1'b0, dat_i.dmag});
    unique case (dat_i.op)
      OP_DIV: begin
        if (qbit) begin
          dat_d.rem = diff[31:0];
        end else begin
          dat_d.rem = r2[31:0];
        end
        dat_d.qd = {dat_i.qd[DIV_W-2:0], qbit};
      end
      OP_TO_FLOAT: begin
        if (!dat_i.qd[DIV_W-1]) begin
          dat_d.qd  = dat_i.qd << 1;
          dat_d.cnt = dat_i.cnt + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;

endmodule
`default_nettype wire

/* hdl/fxalu_post.sv */
// Back end: finish divide, conversions and multiply, select result item.
`default_nettype none
module fxalu_post (
  input  fxalu_pkg::cell_t  dat_i,
  output fxalu_pkg::out_t   out_o
);
  import fxalu_pkg::*;

  logic signed [63:0] t;
  logic [33:0]        fmag;
  logic [33:0]        limit;
  logic [31:0]        nm;
  logic [31:0]        sat;

  always_comb begin
    t     = $signed(dat_i.wide) >>> FRAC_BITS;
    fmag  = {1'b0, dat_i.wide[32:0]} + 34'(dat_i.wide[33]);
    limit = dat_i.qsign ? 34'h0_8000_0000 : 34'h0_7FFF_FFFF;
    nm    = dat_i.qd[DIV_W-1 -: 32];
    sat   = fmag[31:0];
    out_o = '0;
    unique case (dat_i.op)
      OP_FROM_INT, OP_TO_INT, OP_ADD, OP_SUB,
      OP_MIN, OP_MAX, OP_INC, OP_DEC: out_o.result_bits = dat_i.res;
      OP_CMP: begin
        out_o.less    = dat_i.lt;
        out_o.equal   = dat_i.eq;
        out_o.greater = dat_i.gt;
      end
      OP_MUL: begin
        out_o.result_bits = t[31:0];
        out_o.overflow    = !((&t[63:31]) || !(|t[63:31]));
      end
      OP_DIV: begin
        if (dat_i.dmag == 32'd0) begin
          out_o.divide_by_zero = 1'b1;
        end else begin
          out_o.result_bits = dat_i.qsign ? -dat_i.qd[31:0] : dat_i.qd[31:0];
        end
      end
      OP_TO_FLOAT: begin
        if (dat_i.a != 32'd0) begin
          out_o.result_bits = {dat_i.a[31], 8'(EXP_TOP) - 8'(dat_i.cnt), nm[30:8]};
        end
      end
      OP_FROM_FLOAT: begin
        if (dat_i.wide[35]) begin
          out_o.result_bits = dat_i.res;
          out_o.overflow    = dat_i.wide[36];
        end else begin
          if (dat_i.wide[34] || (fmag > limit)) begin
            out_o.overflow = 1'b1;
            sat = limit[31:0];
          end
          out_o.result_bits = dat_i.qsign ? -sat : sat;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/fixed_point_q24_8_alu_unit.sv */
// Top level: Q24.8 ALU with front stage, cell chain, back end and output skid.
// Throughput: one item per cycle unless the output skid holds a spare item;
// the chain of DIV_W cells sets the depth.
// Every operation passes the whole chain, so items leave in order.
// Reset clears all valid flags; payload registers are not reset.
`default_nettype none
module fixed_point_q24_8_alu_unit (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  fxalu_pkg::in_t   in_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output fxalu_pkg::out_t  out_o
);
  import fxalu_pkg::*;

  logic        en;
  logic        vld [DIV_W+1];
  cell_t       dat [DIV_W+1];
  out_t        fin;
  logic        out_valid_q, spr_valid_q;
  out_t        out_q, spr_q;
  logic        push, pop;

  assign en   = !spr_valid_q;
  assign push = en && vld[DIV_W];
  assign pop  = out_valid_q && out_ready_i;

  fxalu_pre u_pre (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .in_i   (in_i),
    .vld_o  (vld[0]),
    .dat_o  (dat[0])
  );

  for (genvar g = 0; g < DIV_W; g++) begin : g_cell
    fxalu_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld[g]),
      .dat_i  (dat[g]),
      .vld_o  (vld[g+1]),
      .dat_o  (dat[g+1])
    );
  end

  fxalu_post u_post (
    .dat_i (dat[DIV_W]),
    .out_o (fin)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      spr_valid_q <= 1'b0;
    end else if (spr_valid_q) begin
      if (pop) begin
        spr_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        spr_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (spr_valid_q) begin
      if (pop) begin
        out_q <= spr_q;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_q <= fin;
      end else begin
        spr_q <= fin;
      end
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_spr_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spr_valid_q |-> out_valid_q)
    else $error("spare item held without output item");

  a_cmp_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({out_o.less, out_o.equal, out_o.greater}))
    else $error("compare flags not exclusive");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.divide_by_zero) |-> (out_o.result_bits == 32'd0))
    else $error("divide by zero with nonzero result");

endmodule
`default_nettype wire

/* verif/testbench.sv */
// Testbench: random and directed items through the Q24.8 ALU, checked against a predictor.
`default_nettype none
module testbench;
  import fxalu_pkg::*;

  class alu_scoreboard;
    out_t pending[$];
    int   errors;

    function automatic logic [31:0] float_to_q(logic [31:0] f, output logic ovf);
      logic        sgn;
      logic [7:0]  bexp;
      logic [63:0] mant, mag, limit;
      int          sh;
      sgn  = f[31];
      bexp = f[30:23];
      mant = {41'd0, f[22:0]};
      ovf  = 1'b0;
      if (bexp == 8'd0) return 32'd0;
      if (bexp == 8'hFF) begin
        ovf = 1'b1;
        if (f[22:0] != 0 || !sgn) return 32'h7FFFFFFF;
        return 32'h80000000;
      end
      mant[23] = 1'b1;
      sh = (23 - FRAC_BITS) - (int'(bexp) - 127);
      if (sh > 0) begin
        if (sh >= 32) mag = 0;
        else mag = (mant >> sh) + ((mant >> (sh - 1)) & 64'd1);
      end else begin
        if (-sh > 40) mag = 64'd1 << 40;
        else mag = mant << (-sh);
      end
      limit = sgn ? 64'h80000000 : 64'h7FFFFFFF;
      if (mag > limit) begin
        ovf = 1'b1;
        mag = limit;
      end
      return sgn ? 32'(64'd0 - mag) : mag[31:0];
    endfunction

    function automatic logic [31:0] q_to_float(logic signed [31:0] a);
      logic [31:0] mag, mant;
      int          p;
      mag = a[31] ? 32'(-64'(a)) : a;
      if (mag == 0) return 32'd0;
      p = 31;
      while (!mag[p]) p--;
      if (p >= 23) mant = (mag >> (p - 23)) & 32'h7FFFFF;
      else mant = (mag << (23 - p)) & 32'h7FFFFF;
      return {a[31], 8'(p - FRAC_BITS + 127), mant[22:0]};
    endfunction

    function automatic out_t compute(in_t it);
      out_t r;
      logic signed [63:0] a, b, t;
      logic ov;
      r = '0;
      a = it.operand_a;
      b = it.operand_b;
      unique case (it.operation)
        OP_FROM_INT:   r.result_bits = 32'(a <<< FRAC_BITS);
        OP_FROM_FLOAT: begin
          r.result_bits = float_to_q(it.float_bits, ov);
          r.overflow = ov;
        end
        OP_TO_FLOAT:   r.result_bits = q_to_float(it.operand_a);
        OP_TO_INT:     r.result_bits = 32'(a >>> FRAC_BITS);
        OP_ADD:        r.result_bits = 32'(a + b);
        OP_SUB:        r.result_bits = 32'(a - b);
        OP_MUL: begin
          t = (a * b) >>> FRAC_BITS;
          r.overflow = (t > 64'sh7FFFFFFF) || (t < -64'sh80000000);
          r.result_bits = t[31:0];
        end
        OP_DIV: begin
          if (b == 0) r.divide_by_zero = 1'b1;
          else begin
            t = (a * 64'sd256) / b;
            r.result_bits = t[31:0];
          end
        end
        OP_CMP: begin
          r.less = a < b;
          r.equal = a == b;
          r.greater = a > b;
        end
        OP_MIN:        r.result_bits = (a > b) ? b[31:0] : a[31:0];
        OP_MAX:        r.result_bits = (b > a) ? b[31:0] : a[31:0];
        OP_INC:        r.result_bits = 32'(a + 1);
        OP_DEC:        r.result_bits = 32'(a - 1);
        default:       r = '0;
      endcase
      return r;
    endfunction

    function void note_item(in_t it);
      pending.push_back(compute(it));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  in_t  in_item;
  out_t out_item;
  alu_scoreboard board;
  bit   quiet;

  fixed_point_q24_8_alu_unit dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .in_i(in_item), .out_valid_o(out_valid), .out_ready_i(out_ready), .out_o(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_item);
    out_ready <= quiet || ($urandom_range(99) >= 19);
  end

  task automatic send(in_t it);
    while (!quiet && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_item(it);
  endtask

  function automatic logic [31:0] edge_word();
    unique case ($urandom_range(7))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 32'd0;
      3: return 32'hFFFFFFFF;
      4: return 32'd1;
      5: return $urandom_range(2047) - 1024;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_float();
    unique case ($urandom_range(5))
      0: return {1'($urandom_range(1)), 8'($urandom_range(110, 160)), 23'($urandom)};
      1: return {1'($urandom_range(1)), 8'hFF,
                 ($urandom_range(1) ? 23'd0 : 23'($urandom))};
      2: return {1'($urandom_range(1)), 8'h00, 23'($urandom)};
      3: return {1'($urandom_range(1)), 8'($urandom_range(100, 130)), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_op(logic [3:0] op, logic [31:0] a, logic [31:0] b, logic [31:0] f);
    in_t it;
    it.operation = op;
    it.operand_a = a;
    it.operand_b = b;
    it.float_bits = f;
    send(it);
  endtask

  initial begin
    in_t it;
    int  cnt;
    board = new();
    quiet = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int op = 0; op < 16; op++)
      send_op(op[3:0], 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
    send_op(OP_DIV, 32'h12345, 32'd0, 32'd0);
    send_op(OP_FROM_FLOAT, 0, 0, 32'h80000000);
    send_op(OP_FROM_FLOAT, 0, 0, 32'h00000001);
    send_op(OP_FROM_FLOAT, 0, 0, 32'h7F800000);
    send_op(OP_FROM_FLOAT, 0, 0, 32'hFF800000);
    send_op(OP_FROM_FLOAT, 0, 0, 32'hFFC00001);
    send_op(OP_FROM_FLOAT, 0, 0, 32'h3F400000);
    send_op(OP_TO_FLOAT, 32'd0, 0, 0);
    send_op(OP_MUL, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
    send_op(OP_CMP, 32'd5, 32'd5, 0);
    for (int i = 0; i < 1500; i++) begin
      quiet = (i >= 600 && i < 800);
      if (i == 1000) begin
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
      end
      it.operation = ($urandom_range(19) == 0) ? 4'($urandom_range(13, 15))
                                               : 4'($urandom_range(12));
      it.operand_a = edge_word();
      it.operand_b = ($urandom_range(9) == 0) ? 32'd0 : edge_word();
      it.float_bits = rand_float();
      send(it);
    end
    in_valid <= 1'b0;
    quiet = 1'b0;
    cnt = 0;
    while (board.pending.size() != 0 && cnt < 100000) begin
      @(posedge clk);
      cnt++;
    end
    repeat (60) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
